[src/bitmap_block_allocator_assert.svh]
// ----------------------------------------------------------------------------
// bitmap_block_allocator_assert.svh
// Assertion macros shared by the allocator checkers.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define BBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define BBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// Types, widths and codes shared by the bitmap block allocator modules.
// ----------------------------------------------------------------------------
package bba_pkg;

  // field and datapath widths
  localparam int WORD_BITS   = 32;
  localparam int WORD_LSB_W  = 5;
  localparam int ADDR_W      = 48;
  localparam int SIZE_W      = 17;
  localparam int CNT_W       = 11;
  localparam int BIDX_W      = 10;
  localparam int TOT_W       = 32;
  localparam int PROD_W      = CNT_W + SIZE_W;
  localparam int DIV_K_W     = 4;
  localparam int SCAN_W      = CNT_W + 1 - WORD_LSB_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 48;

  // defaults and reset values
  localparam int DEF_MAX_BLOCKS  = 1024;
  localparam int RST_BLOCK_COUNT = 1024;
  localparam logic [SIZE_W-1:0]    RST_BLOCK_SIZE = 17'd64;
  localparam logic [ADDR_W-1:0]    RST_POOL_BASE  = '0;
  localparam logic [WORD_BITS-1:0] FULL_WORD      = '1;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_RANGE        = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] block_address;
  } bba_in_t;

  typedef struct packed {
    status_t           status;
    logic [BIDX_W-1:0] block_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_blocks;
    logic [TOT_W-1:0]  alloc_total;
    logic [TOT_W-1:0]  release_total;
  } bba_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_CHK,
    S_A_TAKE,
    S_A_ADD,
    S_F_LIM,
    S_F_DIV,
    S_F_RD,
    S_F_CHK,
    S_DONE
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic    ld_req;
    logic    set_stat;
    status_t stat_code;
    logic    scan_inc;
    logic    a_take;
    logic    a_commit;
    logic    a_add;
    logic    f_sub;
    logic    div_init;
    logic    div_step;
    logic    f_commit;
    logic    out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic free_zero;
    logic word_full;
    logic scan_last;
    logic idx_ok;
    logic range_err;
    logic div_last;
    logic bit_set;
    logic out_busy;
  } dp_stat_t;

endpackage

[src/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

[src/bba_ctl.sv]
// ----------------------------------------------------------------------------
// bba_ctl
// Request sequencer: walks alloc scan, free division and result handoff.
// ----------------------------------------------------------------------------
module bba_ctl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bba_pkg::dp_stat_t st,
  output bba_pkg::dp_cmd_t  cmd
);
  import bba_pkg::*;

  ctl_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (st.is_free)        state_nxt = S_F_LIM;
        else if (st.free_zero) state_nxt = S_DONE;
        else                   state_nxt = S_A_RD;
      end
      S_A_RD: state_nxt = S_A_CHK;
      S_A_CHK: begin
        if (!st.word_full)     state_nxt = S_A_TAKE;
        else if (st.scan_last) state_nxt = S_DONE;
        else                   state_nxt = S_A_RD;
      end
      S_A_TAKE: begin
        state_nxt = st.idx_ok ? S_A_ADD : S_DONE;
      end
      S_A_ADD: state_nxt = S_DONE;
      S_F_LIM: begin
        state_nxt = st.range_err ? S_DONE : S_F_DIV;
      end
      S_F_DIV: begin
        if (st.div_last) state_nxt = S_F_RD;
      end
      S_F_RD:  state_nxt = S_F_CHK;
      S_F_CHK: state_nxt = S_DONE;
      S_DONE: begin
        if (!st.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd           = '0;
    cmd.stat_code = ST_OK;
    in_stall      = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.ld_req = in_valid;
      end
      S_DISPATCH: begin
        if (st.is_free) begin
          cmd.f_sub = 1'b1;
        end else if (st.free_zero) begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = ST_NO_FREE;
        end
      end
      S_A_CHK: begin
        if (!st.word_full) begin
          cmd.a_take = 1'b1;
        end else if (st.scan_last) begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = ST_NO_FREE;
        end else begin
          cmd.scan_inc = 1'b1;
        end
      end
      S_A_TAKE: begin
        if (st.idx_ok) begin
          cmd.a_commit = 1'b1;
        end else begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = ST_NO_FREE;
        end
      end
      S_A_ADD: cmd.a_add = 1'b1;
      S_F_LIM: begin
        if (st.range_err) begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = ST_RANGE;
        end else begin
          cmd.div_init = 1'b1;
        end
      end
      S_F_DIV: cmd.div_step = 1'b1;
      S_F_CHK: begin
        if (st.bit_set) begin
          cmd.f_commit = 1'b1;
        end else begin
          cmd.set_stat  = 1'b1;
          cmd.stat_code = ST_ALREADY_FREE;
        end
      end
      S_DONE: cmd.out_load = !st.out_busy;
      default: ;
    endcase
  end

endmodule

[src/bba_dp.sv]
// ----------------------------------------------------------------------------
// bba_dp
// Allocator datapath: registers, bitmap RAM, address multiply and divide.
// ----------------------------------------------------------------------------
module bba_dp #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  bba_pkg::bba_in_t                    in_data,
  input  logic                                cfg_valid,
  input  logic [bba_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bba_pkg::bba_out_t                   out_data,
  input  bba_pkg::dp_cmd_t                    cmd,
  output bba_pkg::dp_stat_t                   st
);
  import bba_pkg::*;

  // a written count never exceeds the 11-bit register, so storage stops there
  localparam int CLAMP  = (MAX_BLOCKS < 2**CNT_W - 1) ? MAX_BLOCKS : 2**CNT_W - 1;
  localparam int NWORDS = (CLAMP + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam logic [CNT_W-1:0] CLAMP_CNT = CNT_W'(CLAMP);
  localparam logic [CNT_W-1:0] RST_CNT =
    CNT_W'((RST_BLOCK_COUNT > MAX_BLOCKS) ? MAX_BLOCKS : RST_BLOCK_COUNT);

  // configuration
  logic [ADDR_W-1:0] base_r;
  logic [SIZE_W-1:0] size_r;     // zero already mapped to one
  logic [CNT_W-1:0]  count_r;

  // request context
  logic              func_r;
  logic [ADDR_W-1:0] addr_r;
  status_t           status_r;
  logic [SCAN_W-1:0] scan_w_r;
  logic [CNT_W-1:0]  idx_r;
  logic [WORD_BITS-1:0] word_r;
  logic [PROD_W-1:0] prod_r;
  logic [ADDR_W-1:0] granted_r;
  logic [ADDR_W-1:0] diff_r;
  logic              below_r;
  logic [PROD_W-1:0] rem_r;
  logic [DIV_K_W-1:0] k_r;

  // counts and bitmap valid bits
  logic [CNT_W-1:0]  free_cnt_r;
  logic [TOT_W-1:0]  alloc_cnt_r;
  logic [TOT_W-1:0]  rel_cnt_r;
  logic [NWORDS-1:0] vld_r;
  logic              vld_q_r;

  // output register
  logic     out_valid_r;
  bba_out_t out_r;

  logic [WA_W-1:0]      ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_q, ram_wdata, rd_word, zero_1h, bit_mask;
  logic                 ram_we;
  logic [WORD_LSB_W-1:0] lzb;
  logic [CNT_W-1:0]     idx_cand;
  logic [SCAN_W-1:0]    words;
  logic [CNT_W:0]       cnt_round;
  logic [PROD_W-1:0]    mul_a, trial;
  logic [CNT_W-1:0]     cfg_cnt;

  // ---- bitmap storage ----
  assign ram_waddr = idx_r[WORD_LSB_W +: WA_W];
  assign ram_raddr = func_r ? ram_waddr : scan_w_r[WA_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << idx_r[WORD_LSB_W-1:0];
  assign ram_we    = cmd.a_commit || cmd.f_commit;
  assign ram_wdata = cmd.a_commit ? (word_r | bit_mask) : (rd_word & ~bit_mask);

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // a word never written since the last clear reads as all free
  assign rd_word = vld_q_r ? ram_q : '0;

  // lowest clear bit: isolate it, then encode
  assign zero_1h = ~rd_word & (rd_word + WORD_BITS'(1));
  always_comb begin
    lzb = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (zero_1h[i]) lzb = lzb | WORD_LSB_W'(i);
    end
  end
  assign idx_cand = CNT_W'({scan_w_r, lzb});

  // words covering the pool
  assign cnt_round = {1'b0, count_r} + (CNT_W + 1)'(WORD_BITS - 1);
  assign words     = SCAN_W'(cnt_round >> WORD_LSB_W);

  // shared multiplier operand and divider trial value
  assign mul_a = func_r ? PROD_W'(count_r) : PROD_W'(idx_r);
  assign trial = PROD_W'(size_r) << k_r;

  // clamp of a written block count
  assign cfg_cnt = (cfg_data[CNT_W-1:0] > CLAMP_CNT) ? CLAMP_CNT : cfg_data[CNT_W-1:0];

  // ---- status to controller ----
  always_comb begin
    st.is_free   = func_r;
    st.free_zero = (free_cnt_r == '0);
    st.word_full = (rd_word == FULL_WORD);
    st.scan_last = ((scan_w_r + SCAN_W'(1)) >= words);
    st.idx_ok    = (idx_r < count_r);
    st.range_err = below_r || (diff_r >= ADDR_W'(prod_r));
    st.div_last  = (k_r == '0);
    st.bit_set   = rd_word[idx_r[WORD_LSB_W-1:0]];
    st.out_busy  = out_valid_r && out_stall;
  end

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= RST_POOL_BASE;
      size_r  <= RST_BLOCK_SIZE;
      count_r <= RST_CNT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POOL_BASE:   base_r <= cfg_data[ADDR_W-1:0];
        REG_BLOCK_SIZE:  size_r <= (cfg_data[SIZE_W-1:0] == '0) ? SIZE_W'(1)
                                                                 : cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT: count_r <= cfg_cnt;
        default: ;
      endcase
    end
  end

  // ---- counters and valid bits ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r  <= RST_CNT;
      alloc_cnt_r <= '0;
      rel_cnt_r   <= '0;
      vld_r       <= '0;
    end else if (cfg_valid && cfg_index == REG_BLOCK_COUNT) begin
      free_cnt_r <= cfg_cnt;
      vld_r      <= '0;
    end else begin
      if (cmd.a_commit) begin
        free_cnt_r  <= free_cnt_r - CNT_W'(1);
        alloc_cnt_r <= alloc_cnt_r + TOT_W'(1);
      end
      if (cmd.f_commit) begin
        free_cnt_r <= free_cnt_r + CNT_W'(1);
        rel_cnt_r  <= rel_cnt_r + TOT_W'(1);
      end
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q_r <= vld_r[ram_raddr];
  end

  // ---- request working registers ----
  always_ff @(posedge clk) begin
    if (cmd.ld_req) begin
      func_r   <= in_data.func;
      addr_r   <= in_data.block_address;
      status_r <= ST_OK;
      scan_w_r <= '0;
    end
    if (cmd.set_stat) status_r <= cmd.stat_code;
    if (cmd.scan_inc) scan_w_r <= scan_w_r + SCAN_W'(1);
    if (cmd.a_take) begin
      idx_r  <= idx_cand;
      word_r <= rd_word;
    end
    // block address offset on alloc, pool limit on free
    if (cmd.a_commit || cmd.f_sub) prod_r <= mul_a * PROD_W'(size_r);
    if (cmd.a_add) granted_r <= base_r + ADDR_W'(prod_r);
    if (cmd.f_sub) begin
      diff_r  <= addr_r - base_r;
      below_r <= (addr_r < base_r);
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_init) begin
      rem_r <= diff_r[PROD_W-1:0];
      idx_r <= '0;
      k_r   <= DIV_K_W'(CNT_W - 1);
    end
    if (cmd.div_step) begin
      if (rem_r >= trial) begin
        rem_r      <= rem_r - trial;
        idx_r[k_r] <= 1'b1;
      end
      k_r <= k_r - DIV_K_W'(1);
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.status      <= status_r;
      out_r.block_index <= (status_r == ST_OK || status_r == ST_ALREADY_FREE)
                           ? idx_r[BIDX_W-1:0] : '0;
      out_r.granted_address <= (status_r == ST_OK && func_r == FUNC_ALLOC)
                               ? granted_r : '0;
      out_r.free_blocks   <= free_cnt_r;
      out_r.alloc_total   <= alloc_cnt_r;
      out_r.release_total <= rel_cnt_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_block_allocator: fixed-block pool allocator over a used-bit bitmap
// Alloc: scans bitmap words from word 0, up to ceil(block_count/32) of them,
//   each word read from the RAM in S_A_RD and checked in S_A_CHK.
// Free: the address maps to an index through an 11-step quotient loop. One request at a time.
// Reset (sync, active low) clears counters and word valid bits and restores the config registers at once.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
  parameter int MAX_BLOCKS = bba_pkg::DEF_MAX_BLOCKS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bba_pkg::bba_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bba_pkg::bba_out_t              out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  // sequencer
  bba_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath
  bba_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

[src/bba_chk.sv]
// ----------------------------------------------------------------------------
// bba_chk
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bitmap_block_allocator_assert.svh"

module bba_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input bba_pkg::bba_out_t out_data
);
  import bba_pkg::*;

  // one request in flight: an accepted request closes the input side
  `BBA_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")

  // a stalled response holds
  `BBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "response changed under stall")

  // only a granted allocation carries an address
  `BBA_ASSERT_NOW(a_no_addr_on_fail, out_valid && out_data.status != ST_OK, out_data.granted_address == '0, "address on failed request")

  // failed lookups report index zero
  `BBA_ASSERT_NOW(a_idx_zero, out_valid && (out_data.status == ST_NO_FREE || out_data.status == ST_RANGE), out_data.block_index == '0, "index on no-free or range error")

endmodule

bind bitmap_block_allocator bba_chk u_bba_chk (.*);

[test/tb_bitmap_block_allocator.sv]
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator
// Self-checking bench for the bitmap block allocator. Requests go in on a
// valid/stall channel and results come back on another; an in-bench pool
// model predicts every result and a scoreboard compares it field by field.
// A directed opener hits the corner cases, then randomized pool settings run
// alloc-heavy, free-heavy and mixed bursts with malformed frees mixed in.
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int MAP_WORDS      = DEF_MAX_BLOCKS / WORD_BITS;
  localparam int ITEM_TARGET    = 1200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 150;

  // which registers a pool setup writes
  localparam logic [2:0] WR_BASE  = 3'b001;
  localparam logic [2:0] WR_SIZE  = 3'b010;
  localparam logic [2:0] WR_COUNT = 3'b100;
  localparam logic [2:0] WR_ALL   = 3'b111;

  // pool model plus the queue of results it has promised
  class pool_scoreboard;
    logic [ADDR_W-1:0]    pool_base;
    logic [SIZE_W-1:0]    blk_size;
    logic [CNT_W-1:0]     blk_count;
    logic [WORD_BITS-1:0] used_map [MAP_WORDS];
    logic [CNT_W-1:0]     free_cnt;
    logic [TOT_W-1:0]     alloc_cnt;
    logic [TOT_W-1:0]     release_cnt;
    bba_out_t             awaited[$];
    int                   errors;

    function new();
      pool_base   = RST_POOL_BASE;
      blk_size    = RST_BLOCK_SIZE;
      blk_count   = CNT_W'(RST_BLOCK_COUNT);
      alloc_cnt   = '0;
      release_cnt = '0;
      errors      = 0;
      clear_map();
    endfunction

    function void clear_map();
      foreach (used_map[w]) used_map[w] = '0;
      free_cnt = blk_count;
    endfunction

    // a zero block size behaves as one byte
    function longint unsigned step();
      return (blk_size == '0) ? 64'd1 : 64'(blk_size);
    endfunction

    function bit is_used(int idx);
      return used_map[idx / WORD_BITS][idx % WORD_BITS];
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      logic [CNT_W-1:0] cnt;
      cnt = data[CNT_W-1:0];
      case (idx)
        REG_POOL_BASE:  pool_base = data[ADDR_W-1:0];
        REG_BLOCK_SIZE: blk_size  = data[SIZE_W-1:0];
        REG_BLOCK_COUNT: begin
          // counts above the pool capacity clamp; any write empties the pool
          blk_count = (cnt > CNT_W'(DEF_MAX_BLOCKS)) ? CNT_W'(DEF_MAX_BLOCKS) : cnt;
          clear_map();
        end
        default: ;
      endcase
    endfunction

    // random block in range that is used (or free), if there is one
    function bit find_block(bit want_used, output int idx);
      int start;
      int k;
      idx = 0;
      if (blk_count == '0) return 1'b0;
      start = int'($urandom_range(0, int'(blk_count) - 1));
      for (int i = 0; i < int'(blk_count); i++) begin
        k = (start + i) % int'(blk_count);
        if (is_used(k) == want_used) begin
          idx = k;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    // accepted request: update the pool and queue the result it must produce
    function void log_request(bba_in_t req);
      bba_out_t         res;
      int               nwords;
      int               idx;
      bit               found;
      longint unsigned  quot;
      res    = '0;
      res.status = ST_OK;
      found  = 1'b0;
      idx    = 0;
      if (req.func == FUNC_ALLOC) begin
        // lowest clear bit among the words that cover the pool
        if (free_cnt != '0) begin
          nwords = (int'(blk_count) + WORD_BITS - 1) / WORD_BITS;
          for (int w = 0; w < nwords && w < MAP_WORDS && !found; w++) begin
            for (int b = 0; b < WORD_BITS && !found; b++) begin
              if (!used_map[w][b]) begin
                idx   = w * WORD_BITS + b;
                found = 1'b1;
              end
            end
          end
          if (found && idx >= int'(blk_count)) found = 1'b0;
        end
        if (!found) begin
          res.status = ST_NO_FREE;
        end else begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
          free_cnt  = free_cnt - 1'b1;
          alloc_cnt = alloc_cnt + 1'b1;
          res.block_index     = BIDX_W'(idx);
          res.granted_address = ADDR_W'(64'(pool_base) + 64'(idx) * step());
        end
      end else begin
        // address to index, truncating inside a block
        if (req.block_address < pool_base) begin
          res.status = ST_RANGE;
        end else begin
          quot = 64'(req.block_address - pool_base) / step();
          if (quot >= 64'(blk_count)) begin
            res.status = ST_RANGE;
          end else begin
            idx = int'(quot);
            res.block_index = BIDX_W'(idx);
            if (!is_used(idx)) begin
              res.status = ST_ALREADY_FREE;
            end else begin
              used_map[idx / WORD_BITS][idx % WORD_BITS] = 1'b0;
              free_cnt    = free_cnt + 1'b1;
              release_cnt = release_cnt + 1'b1;
            end
          end
        end
      end
      res.free_blocks   = free_cnt;
      res.alloc_total   = alloc_cnt;
      res.release_total = release_cnt;
      awaited.push_back(res);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(bba_out_t got);
      bba_out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no request outstanding, expected none, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare("status",          64'(want.status),          64'(got.status));
      compare("block_index",     64'(want.block_index),     64'(got.block_index));
      compare("granted_address", 64'(want.granted_address), 64'(got.granted_address));
      compare("free_blocks",     64'(want.free_blocks),     64'(got.free_blocks));
      compare("alloc_total",     64'(want.alloc_total),     64'(got.alloc_total));
      compare("release_total",   64'(want.release_total),   64'(got.release_total));
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  bba_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  bba_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  pool_scoreboard sb = new();
  int sent_count  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;
  bit calm_in     = 1'b0;
  bit calm_out    = 1'b0;

  bitmap_block_allocator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10ns clk = ~clk;

  // mostly short idle stretches, now and then a long one
  function automatic int draw_idle();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return int'($urandom_range(1, 3));
    if (r < 95) return int'($urandom_range(4, 10));
    return int'($urandom_range(20, 40));
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // address somewhere inside block idx, aligned half of the time
  function automatic logic [ADDR_W-1:0] block_address(int idx);
    longint unsigned offs;
    offs = ($urandom_range(0, 1) == 0) ? 64'd0 : 64'($urandom) % sb.step();
    return ADDR_W'(64'(sb.pool_base) + 64'(idx) * sb.step() + offs);
  endfunction

  // result side: random stall, check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (stall_left == 0 && !calm_out && $urandom_range(0, 99) < 30) stall_left = draw_idle();
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("** bitmap_block_allocator: FAILED **");
      $finish;
    end
  end

  // one request; valid stays up after acceptance unless the next one waits
  task automatic send_request(logic func, logic [ADDR_W-1:0] addr);
    bba_in_t req;
    int      gap;
    req.func          = func;
    req.block_address = addr;
    gap = (calm_in || $urandom_range(0, 99) < 55) ? 0 : draw_idle();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.log_request(req);
    sent_count++;
  endtask

  // the address field is a don't-care on alloc, so fill it with noise
  task automatic send_alloc();
    send_request(FUNC_ALLOC, rand48());
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // registers change only once every outstanding result is back
  task automatic program_pool(logic [2:0] mask, logic [CFG_DATA_W-1:0] base,
                              logic [CFG_DATA_W-1:0] bsize, logic [CFG_DATA_W-1:0] bcount);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    if ((mask & WR_BASE)  != '0) write_cfg(REG_POOL_BASE, base);
    if ((mask & WR_SIZE)  != '0) write_cfg(REG_BLOCK_SIZE, bsize);
    if ((mask & WR_COUNT) != '0) write_cfg(REG_BLOCK_COUNT, bcount);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    // reset pool: base 0, 64-byte blocks, 1024 blocks
    send_alloc();
    send_alloc();
    send_request(FUNC_FREE, '0);              // address zero is a real block
    send_request(FUNC_FREE, '0);              // double free
    send_request(FUNC_FREE, 48'd127);         // unaligned, frees block 1
    send_request(FUNC_FREE, 48'd65536);       // index just past the pool
    send_request(FUNC_FREE, '1);
    send_alloc();
    // base near the top, largest block size, count above capacity clamps
    program_pool(WR_ALL, 48'hFFFF_FFFF_0000, 48'h1_FFFF, 48'd2047);
    send_alloc();
    send_alloc();                             // granted address wraps
    send_request(FUNC_FREE, '0);              // below base
    send_request(FUNC_FREE, 48'hFFFF_FFFF_0005);
    // zero block size acts as one byte; three-block pool runs dry
    program_pool(WR_ALL, 48'h100, 48'd0, 48'd3);
    send_alloc();
    send_alloc();
    send_alloc();
    send_alloc();
    send_request(FUNC_FREE, 48'h102);
    send_request(FUNC_FREE, 48'hFF);
    send_request(FUNC_FREE, 48'h103);
    send_alloc();
    // empty pool
    program_pool(WR_COUNT, '0, '0, 48'd0);
    send_alloc();
    send_request(FUNC_FREE, 48'h100);
    // single 64 KiB block
    program_pool(WR_ALL, 48'd0, 48'd65536, 48'd1);
    send_alloc();
    send_alloc();
    send_request(FUNC_FREE, 48'd65535);
  endtask

  task automatic run_random_phase();
    logic [2:0]            mask;
    logic [CFG_DATA_W-1:0] base;
    logic [CFG_DATA_W-1:0] bsize;
    logic [CFG_DATA_W-1:0] bcount;
    logic [ADDR_W-1:0]     addr;
    int                    n;
    int                    mode;
    int                    idx;
    int                    r;

    case ($urandom_range(0, 19))
      0, 1, 2:  mask = WR_BASE | WR_SIZE;     // keep the bitmap, move the window
      3:        mask = WR_BASE;
      4:        mask = WR_SIZE;
      5:        mask = WR_COUNT;
      default:  mask = WR_ALL;
    endcase
    case ($urandom_range(0, 5))
      0:       base = '0;
      1:       base = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 1 << 20));
      default: base = rand48();
    endcase
    case ($urandom_range(0, 9))
      0:       bsize = 48'd0;
      1:       bsize = 48'd1;
      2:       bsize = 48'd65536;
      3:       bsize = 48'($urandom_range(65537, 131071));
      4:       bsize = rand48();                 // junk above the field
      default: bsize = 48'($urandom_range(1, 4096));
    endcase
    case ($urandom_range(0, 11))
      0:       bcount = 48'd1024;
      1:       bcount = 48'($urandom_range(1025, 2047));
      2:       bcount = 48'($urandom_range(100, 1023));
      3:       bcount = 48'd0;
      4:       bcount = rand48();
      default: bcount = 48'($urandom_range(1, 64));
    endcase
    program_pool(mask, base, bsize, bcount);

    calm_in  = ($urandom_range(0, 4) == 0);
    calm_out = ($urandom_range(0, 4) == 0);
    n    = int'($urandom_range(30, 90));
    mode = 0;
    for (int i = 0; i < n; i++) begin
      // bursts: 0 fill, 1 drain, 2 mixed
      if (i % 16 == 0) mode = int'($urandom_range(0, 2));
      r = int'($urandom_range(0, 99));
      if (r < 15) begin
        // malformed frees
        case ($urandom_range(0, 3))
          0: addr = rand48();
          1: addr = (sb.pool_base != '0) ? ADDR_W'(64'(rand48()) % 64'(sb.pool_base))
                                         : rand48();
          2: addr = block_address(int'(sb.blk_count) + int'($urandom_range(0, 2)));
          default: begin
            if (sb.find_block(1'b0, idx)) addr = block_address(idx);
            else addr = rand48();
          end
        endcase
        send_request(FUNC_FREE, addr);
      end else if (int'($urandom_range(0, 99)) < ((mode == 0) ? 85 : (mode == 1) ? 20 : 50)) begin
        send_alloc();
      end else begin
        if (!sb.find_block(1'b1, idx)) idx = 0;
        send_request(FUNC_FREE, block_address(idx));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    while (sent_count < ITEM_TARGET) run_random_phase();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** bitmap_block_allocator: PASSED **");
    end else begin
      $display("** bitmap_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/bba_pkg.sv
src/bba_ram.sv
src/bba_ctl.sv
src/bba_dp.sv
src/bitmap_block_allocator.sv
src/bba_chk.sv
test/tb_bitmap_block_allocator.sv
